[hw/rtl/cbta_pkg.sv]
// shared types and constants for the circular bit track access block
package cbta_pkg;

    localparam int MAX_TRACK_BITS_DEF = 131072;
    localparam int MAX_ACCESS_BITS    = 32;
    localparam int CFG_W              = 18;
    localparam int TRACK_LEN_RST      = 131072;
    localparam int CNT_W              = 6;
    localparam int DATA_W             = 32;
    localparam int OUT_POS_W          = 17;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_SEEK  = 2'd2
    } t_req;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [CNT_W-1:0]  bit_count;
        logic [DATA_W-1:0] write_value;
        logic [DATA_W-1:0] seek_position;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0]    read_value;
        logic                 wrapped;
        logic [OUT_POS_W-1:0] position_after;
    } t_out;

endpackage

[hw/rtl/cbta_mod.sv]
// iterative remainder unit: 32-bit dividend modulo a track length, one bit a cycle
module cbta_mod
    import cbta_pkg::*;
#(
    parameter int LEN_W = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [LEN_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [LEN_W-1:0]  o_rem
);

    localparam int IDX_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [IDX_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_dvd;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W:0]    trial;
    logic [LEN_W:0]    diff;

    // shift in the next dividend bit, subtract when it fits
    assign trial = {r_rem, r_dvd[DATA_W-1]};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_cnt <= IDX_W'(DATA_W - 1);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
            r_rem <= (trial >= {1'b0, i_divisor}) ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[hw/rtl/circular_bit_track_access.sv]
// circular bit track: read, write or seek over a byte-wide track memory
//
// An item is taken at a clock edge with start high and busy low. It reads up
// to 32 bits MSB-first, writes the low bit_count bits of write_value
// MSB-first, or seeks to seek_position modulo the track length. Exactly one
// result follows per item, shown for one cycle with o_result_vld high; the
// receiver cannot hold it off. busy falls in the cycle the result is shown,
// so the next item can start there.
// Steps: a read or write loads the byte at the position in S_LOAD, then
// handles its bits in S_BIT, going back to S_LOAD for each new byte; the
// track memory read is registered. A seek waits in S_DIV for the
// bit-serial remainder unit. A zero count or an unused request type gives
// its result straight from idle.
// The track length register is written through i_cfg_valid / o_cfg_ready while
// the block is idle; a write clears position and wrap flag. Reset clears the
// position and wrap flag and sets the full track length; the track memory is
// not cleared, bits must be written before they are read.
module circular_bit_track_access
    import cbta_pkg::*;
#(
    parameter int MAX_TRACK_BITS = MAX_TRACK_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in              i_item,
    output t_out             o_result,
    output logic             o_result_vld,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int POS_W       = $clog2(MAX_TRACK_BITS);
    localparam int LEN_W       = $clog2(MAX_TRACK_BITS + 1);
    localparam int CMP_W       = (CFG_W > LEN_W) ? CFG_W : LEN_W;
    localparam int STORE_BYTES = (MAX_TRACK_BITS + 7) / 8;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int BIT_IDX_W   = $clog2(DATA_W);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_BIT  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (v == '0) begin
            w = CMP_W'(1);
        end else if (w > CMP_W'(MAX_TRACK_BITS)) begin
            w = CMP_W'(MAX_TRACK_BITS);
        end
        return LEN_W'(w);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [POS_W-1:0] p);
        return ADDR_W'(p >> 3);
    endfunction

    t_state            r_state, n_state;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_wrap, n_wrap;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [1:0]        r_type, n_type;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_wval, n_wval;
    logic [DATA_W-1:0] r_rval, n_rval;
    logic [7:0]        r_byte, n_byte;
    t_out              r_out, n_out;
    logic              r_out_vld, n_out_vld;

    logic [7:0]        r_mem [STORE_BYTES];
    logic [7:0]        r_mem_q;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;

    logic              accept;
    logic              cfg_wr;
    logic [POS_W-1:0]  pos0;
    logic [CNT_W-1:0]  cnt_sat;
    logic [7:0]        mask;
    logic              cur_bit;
    logic              wbit;
    logic [7:0]        byte_upd;
    logic [LEN_W-1:0]  pos_inc;
    logic              wrap_now;
    logic [POS_W-1:0]  pos_nx;
    logic              div_start;
    logic              div_done;
    logic [LEN_W-1:0]  div_rem;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy && !start;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // a position at or past the length starts over at 0
    assign pos0    = (LEN_W'(r_pos) >= r_len) ? '0 : r_pos;
    assign cnt_sat = (i_item.bit_count > CNT_W'(MAX_ACCESS_BITS))
                     ? CNT_W'(MAX_ACCESS_BITS) : i_item.bit_count;

    assign mask     = 8'h80 >> r_pos[2:0];
    assign cur_bit  = |(r_byte & mask);
    assign wbit     = r_wval[BIT_IDX_W'(r_cnt - 1'b1)];
    assign byte_upd = wbit ? (r_byte | mask) : (r_byte & ~mask);
    assign pos_inc  = LEN_W'(r_pos) + 1'b1;
    assign wrap_now = (pos_inc >= r_len);
    assign pos_nx   = wrap_now ? '0 : POS_W'(pos_inc);

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_wrap    = r_wrap;
        n_len     = r_len;
        n_type    = r_type;
        n_cnt     = r_cnt;
        n_wval    = r_wval;
        n_rval    = r_rval;
        n_byte    = r_byte;
        n_out     = r_out;
        n_out_vld = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_of(r_pos);
        mem_raddr = addr_of(r_pos);
        div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (cfg_wr) begin
                    n_len  = eff_len(i_cfg_data);
                    n_pos  = '0;
                    n_wrap = 1'b0;
                end else if (accept) begin
                    n_pos  = pos0;
                    n_type = i_item.req_type;
                    n_cnt  = cnt_sat;
                    n_wval = i_item.write_value;
                    n_rval = '0;
                    mem_raddr = addr_of(pos0);
                    if ((i_item.req_type inside {REQ_READ, REQ_WRITE}) && cnt_sat != '0) begin
                        n_state = S_LOAD;
                    end else if (i_item.req_type == REQ_SEEK) begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        n_out.read_value     = '0;
                        n_out.wrapped        = r_wrap;
                        n_out.position_after = OUT_POS_W'(pos0);
                        n_out_vld            = 1'b1;
                    end
                end
            end
            S_LOAD: begin
                n_byte  = r_mem_q;
                n_state = S_BIT;
            end
            S_BIT: begin
                if (r_type == REQ_WRITE) begin
                    n_byte = byte_upd;
                end else begin
                    n_rval = {r_rval[DATA_W-2:0], cur_bit};
                end
                n_pos = pos_nx;
                if (wrap_now) begin
                    n_wrap = 1'b1;
                end
                n_cnt     = r_cnt - 1'b1;
                mem_raddr = addr_of(pos_nx);
                // leaving this byte: a write stores it back; fetch the next
                if (r_cnt == CNT_W'(1) || addr_of(pos_nx) != addr_of(r_pos)) begin
                    mem_we = (r_type == REQ_WRITE);
                    if (r_cnt == CNT_W'(1)) begin
                        n_out.read_value     = (r_type == REQ_WRITE) ? r_rval
                                               : {r_rval[DATA_W-2:0], cur_bit};
                        n_out.wrapped        = r_wrap | wrap_now;
                        n_out.position_after = OUT_POS_W'(pos_nx);
                        n_out_vld            = 1'b1;
                        n_state              = S_IDLE;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_pos                = POS_W'(div_rem);
                    n_wrap               = 1'b0;
                    n_out.read_value     = '0;
                    n_out.wrapped        = 1'b0;
                    n_out.position_after = OUT_POS_W'(div_rem);
                    n_out_vld            = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_wrap    <= 1'b0;
            r_len     <= eff_len(CFG_W'(TRACK_LEN_RST));
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_wrap    <= n_wrap;
            r_len     <= n_len;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        r_cnt  <= n_cnt;
        r_wval <= n_wval;
        r_rval <= n_rval;
        r_byte <= n_byte;
        r_out  <= n_out;
    end

    // track memory, a read of the byte being written back is never used
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= byte_upd;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    cbta_mod #(
        .LEN_W (LEN_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_item.seek_position),
        .i_divisor  (r_len),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign o_result     = r_out;
    assign o_result_vld = r_out_vld;

endmodule

[tb/sv/tb_top.sv]
// testbench for the circular bit track access block: shadow track, random requests, result check
`timescale 1ns / 100ps

module tb_top;
    import cbta_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 70;
    localparam int SETTLE_CYCLES = 50;

    // shadow of the track: bit store, position, wrap flag and length register
    class track_shadow;
        bit [CFG_W-1:0] len_reg;
        int unsigned    pos;
        bit             wrap;
        bit             track_bits [MAX_TRACK_BITS_DEF];
        bit             written [MAX_TRACK_BITS_DEF];
        t_out           due_results [$];
        int             errors;

        function new();
            len_reg = CFG_W'(TRACK_LEN_RST);
            pos     = 0;
            wrap    = 1'b0;
            errors  = 0;
        endfunction

        function int unsigned span_bits();
            if (len_reg == 0)
                return 1;
            if (len_reg > MAX_TRACK_BITS_DEF)
                return MAX_TRACK_BITS_DEF;
            return 32'(len_reg);
        endfunction

        function void set_length(logic [CFG_W-1:0] v);
            len_reg = v;
            pos     = 0;
            wrap    = 1'b0;
        endfunction

        function void advance(int unsigned span);
            pos++;
            if (pos >= span) begin
                pos  = 0;
                wrap = 1'b1;
            end
        endfunction

        // consecutive written bits from the current position, up to one access
        function int unsigned readable_run();
            int unsigned span;
            int unsigned p;
            int unsigned n;
            span = span_bits();
            p    = (pos >= span) ? 0 : pos;
            n    = 0;
            while (n < MAX_ACCESS_BITS && written[p]) begin
                n++;
                p = (p + 1 >= span) ? 0 : p + 1;
            end
            return n;
        endfunction

        function void take_request(t_in it);
            int unsigned span;
            int unsigned n;
            int unsigned i;
            t_out r;
            span = span_bits();
            n    = (it.bit_count > MAX_ACCESS_BITS) ? MAX_ACCESS_BITS : 32'(it.bit_count);
            r    = '0;
            if (pos >= span)
                pos = 0;
            case (it.req_type)
                REQ_READ: begin
                    for (i = 0; i < n; i++) begin
                        r.read_value = {r.read_value[DATA_W-2:0], track_bits[pos]};
                        advance(span);
                    end
                end
                REQ_WRITE: begin
                    for (i = n; i > 0; i--) begin
                        track_bits[pos] = it.write_value[i-1];
                        written[pos]    = 1'b1;
                        advance(span);
                    end
                end
                REQ_SEEK: begin
                    pos  = it.seek_position % span;
                    wrap = 1'b0;
                end
                default: ;
            endcase
            r.wrapped        = wrap;
            r.position_after = pos[OUT_POS_W-1:0];
            due_results.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (due_results.size() == 0) begin
                if (errors < 10)
                    $display("result with none expected: %h", got);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.read_value !== want.read_value || got.wrapped !== want.wrapped ||
                got.position_after !== want.position_after) begin
                if (errors < 10)
                    $display({"mismatch: read_value exp %h got %h, wrapped exp %b got %b,",
                              " position_after exp %0d got %0d"},
                             want.read_value, got.read_value, want.wrapped, got.wrapped,
                             want.position_after, got.position_after);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_in              i_item = '0;
    t_out             o_result;
    logic             o_result_vld;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data = '0;

    track_shadow      shadow;
    int unsigned      write_starts [$];
    bit               gaps_on = 1'b1;
    int               cycles = 0;

    circular_bit_track_access u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_result     (o_result),
        .o_result_vld (o_result_vld),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_vld === 1'b1)
            shadow.check_result(o_result);
    end

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in req(logic [1:0] t, logic [CNT_W-1:0] c,
                                logic [DATA_W-1:0] w, logic [DATA_W-1:0] s);
        t_in it;
        it.req_type      = t;
        it.bit_count     = c;
        it.write_value   = w;
        it.seek_position = s;
        return it;
    endfunction

    // mostly legal reads over written bits, writes and seeks back to written spots
    function automatic t_in random_request();
        t_in         it;
        int unsigned span;
        int unsigned run;
        int unsigned pick;
        int unsigned target;
        longint unsigned room;
        longint unsigned k;
        it.req_type      = 2'($urandom_range(0, 3));
        it.bit_count     = CNT_W'($urandom_range(0, 63));
        it.write_value   = $urandom;
        it.seek_position = $urandom;
        span = shadow.span_bits();
        run  = shadow.readable_run();
        pick = $urandom_range(0, 99);
        if (pick < 35 && run == 0)
            pick = 50;
        if (pick < 35) begin
            it.req_type = REQ_READ;
            if (run == MAX_ACCESS_BITS && $urandom_range(0, 9) == 0)
                it.bit_count = CNT_W'($urandom_range(MAX_ACCESS_BITS + 1, 63));
            else
                it.bit_count = CNT_W'($urandom_range(1, run));
        end else if (pick < 70) begin
            it.req_type = REQ_WRITE;
            case ($urandom_range(0, 19))
                0: it.bit_count = '0;
                1: it.bit_count = CNT_W'($urandom_range(MAX_ACCESS_BITS + 1, 63));
                default: it.bit_count = CNT_W'($urandom_range(1, MAX_ACCESS_BITS));
            endcase
            write_starts.push_back(shadow.pos);
            if (write_starts.size() > 16)
                void'(write_starts.pop_front());
        end else if (pick < 90) begin
            it.req_type = REQ_SEEK;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    if (write_starts.size() != 0) begin
                        target = write_starts[$urandom_range(0, write_starts.size() - 1)];
                        if (target < span) begin
                            room = (64'hFFFF_FFFF - target) / span;
                            k    = 64'($urandom_range(0, 32'(room)));
                            it.seek_position = DATA_W'(target + k * span);
                        end
                    end
                end
                5, 6: begin
                    // land just short of the end so a following access can wrap
                    it.seek_position = span - 1 - $urandom_range(0, (span > 32) ? 31 : span - 1);
                end
                default: ;
            endcase
        end else if (pick < 95) begin
            it.req_type = REQ_UNUSED;
        end else begin
            it.req_type  = ($urandom_range(0, 1) != 0) ? REQ_WRITE : REQ_READ;
            it.bit_count = '0;
        end
        return it;
    endfunction

    task automatic issue(input t_in it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        shadow.take_request(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (shadow.due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] v);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        shadow.set_length(v);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] lengths [$];
        shadow = new();
        lengths = '{18'd1, 18'd2, 18'd7, 18'd8, 18'd9, 18'd33, 18'd100, 18'd1000,
                    18'd0, 18'd131071, 18'h3FFFF, 18'd131072, 18'd5, 18'd64, 18'd4096,
                    CFG_W'($urandom_range(1, 131072))};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-length track from reset
        issue(req(REQ_WRITE, 6'd32, 32'hFFFF_FFFF, 32'h0));
        issue(req(REQ_WRITE, 6'd63, 32'hA5A5_5A5A, 32'h0));
        issue(req(REQ_WRITE, 6'd0, 32'h1234_5678, 32'h0));
        issue(req(REQ_UNUSED, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        issue(req(REQ_SEEK, 6'd0, 32'h0, 32'h0));
        issue(req(REQ_READ, 6'd32, 32'h0, 32'h0));
        issue(req(REQ_READ, 6'd63, 32'h0, 32'h0));
        issue(req(REQ_READ, 6'd0, 32'h0, 32'h0));
        issue(req(REQ_SEEK, 6'd0, 32'h0, 32'hFFFF_FFFF));
        issue(req(REQ_WRITE, 6'd1, 32'h1, 32'h0));
        issue(req(REQ_READ, 6'd1, 32'h0, 32'h0));
        issue(req(REQ_SEEK, 6'd0, 32'h0, 32'd131071));
        issue(req(REQ_READ, 6'd2, 32'h0, 32'h0));
        issue(req(REQ_SEEK, 6'd0, 32'h0, 32'd131040));
        issue(req(REQ_WRITE, 6'd32, 32'h0, 32'h0));
        issue(req(REQ_SEEK, 6'd0, 32'h0, 32'd131040));
        issue(req(REQ_READ, 6'd32, 32'h0, 32'h0));
        issue(req(REQ_READ, 6'd32, 32'h0, 32'h0));

        // zero length acts as a one-bit track
        drain();
        write_length('0);
        issue(req(REQ_WRITE, 6'd1, 32'h0, 32'h0));
        issue(req(REQ_READ, 6'd32, 32'h0, 32'h0));
        issue(req(REQ_WRITE, 6'd3, 32'h5, 32'h0));
        issue(req(REQ_READ, 6'd5, 32'h0, 32'h0));
        issue(req(REQ_SEEK, 6'd0, 32'h0, 32'hFFFF_FFFF));

        // oversize length acts as the full track
        drain();
        write_length(18'h3FFFF);
        issue(req(REQ_SEEK, 6'd0, 32'h0, 32'd393215));
        issue(req(REQ_READ, 6'd1, 32'h0, 32'h0));

        foreach (lengths[i]) begin
            drain();
            write_length(lengths[i]);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) issue(random_request());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.due_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
